### rtl/stq_pkg.sv
package stq_pkg;

   localparam int HANDLE_COUNT = 16;
   localparam int HANDLE_W     = 4;

   typedef enum logic [2:0] {
      ACT_INS_HEAD = 3'd0,
      ACT_INS_TAIL = 3'd1,
      ACT_REMOVE   = 3'd2,
      ACT_CHANGE   = 3'd3,
      ACT_EXPIRE   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_NO_HDL = 2'd3
   } status_type;

   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  handle;
      logic [31:0] expires;
      logic [31:0] tag;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [3:0]  out_handle;
      logic [31:0] out_tag;
      logic [31:0] time_to_next;
      logic        last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request
      logic ins;       // shift-insert latched entry
      logic unlink;    // shift-remove at found position
      logic pop;       // drop head entry
      logic free_hdl;  // clear in-use bit of latched handle
      logic take_hdl;  // set in-use bit of latched handle
      logic head_side; // insert before equal expiries
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       full;
      logic       empty;
      logic       found;
      logic       same_exp;
      logic       head_due;
      logic [2:0] action;
   } sts_type;

endpackage

### rtl/stq_datapath.sv
module stq_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  stq_pkg::req_type req,
   input  stq_pkg::cmd_type cmd,
   output stq_pkg::sts_type sts,
   output logic [3:0]       head_handle,
   output logic [31:0]      head_tag,
   output logic [3:0]       alloc_handle,
   output logic [3:0]       req_handle,
   output logic [31:0]      time_to_next
);
   import stq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   // cell chain
   logic [31:0] exp_ff [CAPACITY];
   logic [31:0] tag_ff [CAPACITY];
   logic [3:0]  hdl_ff [CAPACITY];
   logic [CW-1:0] count_ff, count_in;
   logic [HANDLE_COUNT-1:0] used_ff, used_in;
   req_type req_ff;
   logic [3:0] hsel_ff;  // handle being inserted or named
   logic [31:0] tsel_ff; // tag being inserted

   logic [CAPACITY-1:0] valid, ahead, match, at_gap;
   logic [3:0] free_h;
   logic any_free;

   // per-cell compares
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid[i] = (CW'(i) < count_ff);
         ahead[i] = valid[i] && (cmd.head_side ? (exp_ff[i] < req_ff.expires)
                                               : (exp_ff[i] <= req_ff.expires));
         match[i] = valid[i] && (hdl_ff[i] == req_ff.handle);
      end
   end

   // cells at or past the matching cell
   always_comb begin
      at_gap[0] = match[0];
      for (int i = 1; i < CAPACITY; i++)
         at_gap[i] = at_gap[i-1] | match[i];
   end

   // lowest free handle
   always_comb begin
      free_h   = '0;
      any_free = 1'b0;
      for (int h = HANDLE_COUNT - 1; h >= 0; h--) begin
         if (!used_ff[h]) begin
            free_h   = 4'(h);
            any_free = 1'b1;
         end
      end
   end

   // capture request; hold handle/tag for the insert step
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req;
         hsel_ff <= (req.action == ACT_INS_HEAD || req.action == ACT_INS_TAIL)
                    ? free_h : req.handle;
         tsel_ff <= req.tag;
      end else if (cmd.unlink) begin
         for (int i = 0; i < CAPACITY; i++)
            if (match[i]) tsel_ff <= tag_ff[i];
      end
   end

   // shift chain
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (cmd.ins) begin
            if (!ahead[i]) begin
               if (i == 0 || ahead[i-1]) begin
                  exp_ff[i] <= req_ff.expires;
                  tag_ff[i] <= tsel_ff;
                  hdl_ff[i] <= hsel_ff;
               end else begin
                  exp_ff[i] <= exp_ff[i-1];
                  tag_ff[i] <= tag_ff[i-1];
                  hdl_ff[i] <= hdl_ff[i-1];
               end
            end
         end else if (cmd.unlink || cmd.pop) begin
            // cells at or past the gap take their successor
            if (i < CAPACITY - 1 && (cmd.pop || at_gap[i])) begin
               exp_ff[i] <= exp_ff[i+1];
               tag_ff[i] <= tag_ff[i+1];
               hdl_ff[i] <= hdl_ff[i+1];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.ins) count_in = count_ff + 1'b1;
      else if (cmd.unlink || cmd.pop) count_in = count_ff - 1'b1;
      used_in = used_ff;
      if (cmd.take_hdl) used_in[hsel_ff] = 1'b1;
      if (cmd.free_hdl) used_in[hsel_ff] = 1'b0;
      if (cmd.pop) used_in[hdl_ff[0]] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         used_ff  <= '0;
      end else begin
         count_ff <= count_in;
         used_ff  <= used_in;
      end
   end

   always_comb begin
      sts.full     = (count_ff == CW'(CAPACITY)) || !any_free;
      sts.empty    = (count_ff == '0);
      sts.found    = used_ff[req_ff.handle] && (|match);
      sts.same_exp = 1'b0;
      for (int i = 0; i < CAPACITY; i++)
         if (match[i] && exp_ff[i] == req_ff.expires) sts.same_exp = 1'b1;
      sts.head_due = !sts.empty && (exp_ff[0] <= req_ff.now);
      sts.action   = req_ff.action;
   end

   assign head_handle  = hdl_ff[0];
   assign head_tag     = tag_ff[0];
   assign alloc_handle = hsel_ff;
   assign req_handle   = req_ff.handle;
   assign time_to_next = sts.empty ? '0 : exp_ff[0] - req_ff.now;

endmodule

### rtl/stq_ctrl.sv
module stq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output stq_pkg::cmd_type cmd,
   input  stq_pkg::sts_type sts,
   input  logic [3:0]       head_handle,
   input  logic [31:0]      head_tag,
   input  logic [3:0]       alloc_handle,
   input  logic [3:0]       req_handle,
   input  logic [31:0]      time_to_next,
   output logic             rsp_valid,
   output stq_pkg::rsp_type rsp
);
   import stq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECIDE = 4'b0010,
      S_REINS  = 4'b0100,
      S_EXPIRE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.last  = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            case (sts.action)
               ACT_INS_HEAD, ACT_INS_TAIL: begin
                  if (sts.full) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     cmd.ins       = 1'b1;
                     cmd.take_hdl  = 1'b1;
                     cmd.head_side = (sts.action == ACT_INS_HEAD);
                     rsp_in.out_handle = alloc_handle;
                  end
               end
               ACT_REMOVE, ACT_CHANGE: begin
                  rsp_in.out_handle = req_handle;
                  if (sts.empty) rsp_in.status = ST_EMPTY;
                  else if (!sts.found) rsp_in.status = ST_NO_HDL;
                  else if (sts.action == ACT_REMOVE) begin
                     cmd.unlink   = 1'b1;
                     cmd.free_hdl = 1'b1;
                  end else if (!sts.same_exp) begin
                     cmd.unlink   = 1'b1;
                     rsp_valid_in = 1'b0;
                     state_in     = S_REINS;
                  end
               end
               ACT_EXPIRE: begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_EXPIRE;
               end
               default: ;
            endcase
         end
         S_REINS: begin
            cmd.ins           = 1'b1;
            cmd.head_side     = 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_in.out_handle = req_handle;
            state_in          = S_IDLE;
         end
         S_EXPIRE: begin
            rsp_valid_in = 1'b1;
            if (sts.head_due) begin
               cmd.pop           = 1'b1;
               rsp_in.kind       = KIND_REPORT;
               rsp_in.out_handle = head_handle;
               rsp_in.out_tag    = head_tag;
               rsp_in.last       = 1'b0;
            end else begin
               rsp_in.time_to_next = time_to_next;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) rsp_ff <= rsp_in;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### rtl/sorted_timer_queue_top.sv
// Channel   Ports                       Transfer when
// request   start, busy, req_item       start && !busy
// response  rsp_valid, rsp_item         rsp_valid (one cycle, no backpressure)
//
// Insert, remove and unchanged change pass through IDLE and DECIDE. Change with a new expiry
// adds a REINS step (unlink and reinsert are separate shifts of the cell chain).
// Expire adds an EXPIRE step that reports one expired entry per cycle; the summary ends the sequence.
// Results are registered and appear in the cycle after the step that makes them.
// Synchronous reset clears count and handle mask; no clearing pass.
module sorted_timer_queue_top #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  stq_pkg::req_type req_item,
   output logic             rsp_valid,
   output stq_pkg::rsp_type rsp_item
);
   import stq_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [3:0]  head_handle, alloc_handle, req_handle;
   logic [31:0] head_tag, time_to_next;

   stq_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock, .reset, .req(req_item), .cmd, .sts, .head_handle, .head_tag,
      .alloc_handle, .req_handle, .time_to_next
   );

   stq_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .cmd, .sts, .head_handle, .head_tag,
      .alloc_handle, .req_handle, .time_to_next, .rsp_valid, .rsp(rsp_item)
   );

endmodule

### rtl/stq_checker.sv
module stq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input stq_pkg::rsp_type rsp_item
);
   import stq_pkg::*;

   // a transfer always makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("not busy after transfer");

   // entry reports are followed by another result
   a_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |=> rsp_valid) else $error("broken expire run");

   // reports never carry the last mark
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind |-> !rsp_item.last) else $error("report marked last");

   // no result while the block stays idle and takes no request
   a_idle: assert property (@(posedge clock) disable iff (reset)
      !busy && $past(!busy) && !$past(start) |-> !rsp_valid)
      else $error("stray result");

endmodule

bind sorted_timer_queue_top stq_checker u_chk (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_item
);

### sim/sorted_timer_queue_top_tb.sv
module sorted_timer_queue_top_tb;
   import stq_pkg::*;

   localparam int DEPTH     = 16;
   localparam int RAND_OPS  = 410;
   localparam int MAX_CYCLE = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   sorted_timer_queue_top #(.CAPACITY(DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the queue
   logic [31:0] q_exp [DEPTH];
   logic [31:0] q_tag [DEPTH];
   logic [3:0]  q_hdl [DEPTH];
   int          q_count;
   logic [15:0] hdl_busy;

   rsp_type pending_rsp[$];
   int      errors = 0;
   int      idle_pct = 0;
   longint  cycle_count = 0;

   function automatic rsp_type mk_rsp(logic k, status_type s, logic [3:0] h,
                                      logic [31:0] t, logic [31:0] n, logic l);
      rsp_type r;
      r.kind = k; r.status = s; r.out_handle = h;
      r.out_tag = t; r.time_to_next = n; r.last = l;
      return r;
   endfunction

   function automatic void shadow_place(logic [31:0] e, logic [31:0] t,
                                        logic [3:0] h, bit tail);
      int p;
      p = 0;
      while (p < q_count && (tail ? !(q_exp[p] > e) : !(q_exp[p] >= e))) p++;
      for (int i = q_count; i > p; i--) begin
         q_exp[i] = q_exp[i-1]; q_tag[i] = q_tag[i-1]; q_hdl[i] = q_hdl[i-1];
      end
      q_exp[p] = e; q_tag[p] = t; q_hdl[p] = h;
      q_count++;
   endfunction

   function automatic void shadow_unlink(int p);
      for (int i = p; i + 1 < q_count; i++) begin
         q_exp[i] = q_exp[i+1]; q_tag[i] = q_tag[i+1]; q_hdl[i] = q_hdl[i+1];
      end
      q_count--;
   endfunction

   // predict the results of one accepted request
   function automatic void predict_queue_op(req_type r);
      int h, p;
      p = -1;
      case (r.action)
         ACT_INS_HEAD, ACT_INS_TAIL: begin
            h = 0;
            while (h < 16 && hdl_busy[h]) h++;
            if (q_count >= DEPTH || h >= 16) begin
               pending_rsp.push_back(mk_rsp(KIND_ACK, ST_FULL, 4'd0, '0, '0, 1'b1));
            end else begin
               hdl_busy[h] = 1'b1;
               shadow_place(r.expires, r.tag, h[3:0], r.action == ACT_INS_TAIL);
               pending_rsp.push_back(mk_rsp(KIND_ACK, ST_OK, h[3:0], '0, '0, 1'b1));
            end
         end
         ACT_REMOVE, ACT_CHANGE: begin
            for (int i = 0; i < q_count; i++) if (p < 0 && q_hdl[i] == r.handle) p = i;
            if (q_count == 0) begin
               pending_rsp.push_back(mk_rsp(KIND_ACK, ST_EMPTY, r.handle, '0, '0, 1'b1));
            end else if (!hdl_busy[r.handle] || p < 0) begin
               pending_rsp.push_back(mk_rsp(KIND_ACK, ST_NO_HDL, r.handle, '0, '0, 1'b1));
            end else begin
               if (r.action == ACT_REMOVE) begin
                  shadow_unlink(p);
                  hdl_busy[r.handle] = 1'b0;
               end else if (q_exp[p] != r.expires) begin
                  logic [31:0] t;
                  t = q_tag[p];
                  shadow_unlink(p);
                  shadow_place(r.expires, t, r.handle, 1'b0);
               end
               pending_rsp.push_back(mk_rsp(KIND_ACK, ST_OK, r.handle, '0, '0, 1'b1));
            end
         end
         ACT_EXPIRE: begin
            while (q_count > 0 && q_exp[0] <= r.now) begin
               pending_rsp.push_back(mk_rsp(KIND_REPORT, ST_OK, q_hdl[0], q_tag[0],
                                            '0, 1'b0));
               hdl_busy[q_hdl[0]] = 1'b0;
               shadow_unlink(0);
            end
            pending_rsp.push_back(mk_rsp(KIND_ACK, ST_OK, 4'd0, '0,
                                         q_count > 0 ? q_exp[0] - r.now : 32'd0, 1'b1));
         end
         default: pending_rsp.push_back(mk_rsp(KIND_ACK, ST_OK, 4'd0, '0, '0, 1'b1));
      endcase
   endfunction

   // check each result transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $realtime, rsp_item);
            errors++;
         end else begin
            rsp_type want;
            want = pending_rsp.pop_front();
            if (rsp_item !== want) begin
               $display("%0t: mismatch, expected %p, actual %p", $realtime, want, rsp_item);
               errors++;
            end
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLE) begin
         $display("sorted_timer_queue_top_tb NOT OK");
         $finish;
      end
   end

   // drive one request, holding start until the transfer
   task automatic send_req(req_type r);
      while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      predict_queue_op(r);
      @(negedge clock);
   endtask

   function automatic req_type mk_req(action_type a, logic [3:0] h, logic [31:0] e,
                                      logic [31:0] t, logic [31:0] n);
      req_type r;
      r.action = a; r.handle = h; r.expires = e; r.tag = t; r.now = n;
      return r;
   endfunction

   function automatic req_type rand_req();
      req_type r;
      int sel;
      logic [31:0] base;
      sel  = $urandom_range(99, 0);
      base = $urandom_range(3, 0) == 0 ? $urandom() : 32'd1000;
      r.handle  = $urandom_range(3, 0) == 0 ? 4'($urandom()) :
                  (q_count > 0 ? q_hdl[$urandom_range(q_count - 1, 0)] : 4'd0);
      r.expires = $urandom_range(1, 0) ? base + $urandom_range(40, 0) : $urandom();
      r.tag     = $urandom();
      r.now     = $urandom_range(4, 0) == 0 ? $urandom() : 32'd1000 + $urandom_range(45, 0);
      if (sel < 30)      r.action = ACT_INS_HEAD;
      else if (sel < 55) r.action = ACT_INS_TAIL;
      else if (sel < 70) r.action = ACT_REMOVE;
      else if (sel < 85) r.action = ACT_CHANGE;
      else if (sel < 97) r.action = ACT_EXPIRE;
      else               r.action = 3'($urandom_range(7, 5));
      return r;
   endfunction

   // directed rows; a row with a typed-in answer is checked against it as well
   typedef struct {
      req_type r;
      bit      fixed;
      rsp_type ans;
   } dir_row_type;

   dir_row_type dir_rows[$];

   initial begin
      req_type r;
      int      wait_cycles;
      q_count  = 0;
      hdl_busy = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      dir_rows.push_back('{mk_req(ACT_REMOVE, 4'd0, '0, '0, '0), 1,
                           mk_rsp(KIND_ACK, ST_EMPTY, 4'd0, '0, '0, 1'b1)});
      dir_rows.push_back('{mk_req(ACT_CHANGE, 4'd15, '1, '0, '0), 1,
                           mk_rsp(KIND_ACK, ST_EMPTY, 4'd15, '0, '0, 1'b1)});
      dir_rows.push_back('{mk_req(ACT_EXPIRE, '0, '0, '0, '1), 1,
                           mk_rsp(KIND_ACK, ST_OK, 4'd0, '0, '0, 1'b1)});
      dir_rows.push_back('{mk_req(ACT_INS_HEAD, '0, '1, '1, '0), 1,
                           mk_rsp(KIND_ACK, ST_OK, 4'd0, '0, '0, 1'b1)});
      dir_rows.push_back('{mk_req(ACT_INS_TAIL, '1, '0, '0, '1), 1,
                           mk_rsp(KIND_ACK, ST_OK, 4'd1, '0, '0, 1'b1)});
      dir_rows.push_back('{mk_req(ACT_REMOVE, 4'd9, '0, '0, '0), 1,
                           mk_rsp(KIND_ACK, ST_NO_HDL, 4'd9, '0, '0, 1'b1)});
      dir_rows.push_back('{mk_req(action_type'(3'd5), '1, '1, '1, '1), 1,
                           mk_rsp(KIND_ACK, ST_OK, 4'd0, '0, '0, 1'b1)});
      dir_rows.push_back('{mk_req(action_type'(3'd7), '0, '0, '0, '0), 1,
                           mk_rsp(KIND_ACK, ST_OK, 4'd0, '0, '0, 1'b1)});
      // equal expiries on both sides, unchanged and moved change
      dir_rows.push_back('{mk_req(ACT_INS_TAIL, '0, 32'd50, 32'hA5A5A5A5, '0), 0, '0});
      dir_rows.push_back('{mk_req(ACT_INS_HEAD, '0, 32'd50, 32'h5A5A5A5A, '0), 0, '0});
      dir_rows.push_back('{mk_req(ACT_INS_TAIL, '0, 32'd50, 32'h12345678, '0), 0, '0});
      dir_rows.push_back('{mk_req(ACT_CHANGE, 4'd2, 32'd50, '0, '0), 0, '0});
      dir_rows.push_back('{mk_req(ACT_CHANGE, 4'd3, 32'd20, '0, '0), 0, '0});
      dir_rows.push_back('{mk_req(ACT_CHANGE, 4'd0, 32'd50, '0, '0), 0, '0});
      dir_rows.push_back('{mk_req(ACT_EXPIRE, '0, '0, '0, 32'd50), 0, '0});
      dir_rows.push_back('{mk_req(ACT_REMOVE, 4'd0, '0, '0, '0), 0, '0});
      // fill to capacity, then one over
      for (int i = 0; i < 16; i++)
         dir_rows.push_back('{mk_req(ACT_INS_HEAD, '0, 32'(i * 7), 32'(i), '0), 0, '0});
      dir_rows.push_back('{mk_req(ACT_INS_TAIL, '0, '0, '0, '0), 1,
                           mk_rsp(KIND_ACK, ST_FULL, 4'd0, '0, '0, 1'b1)});
      dir_rows.push_back('{mk_req(ACT_EXPIRE, '0, '0, '0, '1), 0, '0});

      foreach (dir_rows[i]) begin
         send_req(dir_rows[i].r);
         if (dir_rows[i].fixed && pending_rsp[$] !== dir_rows[i].ans) begin
            $display("%0t: row %0d expected %p, actual prediction %p", $realtime, i,
                     dir_rows[i].ans, pending_rsp[$]);
            errors++;
         end
      end

      // random part in four idling phases
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 65 : (ph == 3) ? 24 : 0;
         for (int i = 0; i < RAND_OPS / 4; i++) begin
            r = rand_req();
            send_req(r);
         end
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (pending_rsp.size() > 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("sorted_timer_queue_top_tb OK");
      else
         $display("sorted_timer_queue_top_tb NOT OK");
      $finish;
   end

endmodule
